[rtl/core/aprq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the aging priority ready queue.
// No dependencies; every other file imports it.
package aprq_pkg;

   localparam int ID_W      = 8;
   localparam int PRIO_W    = 32;
   localparam int TIME_W    = 32;
   localparam int WEIGHT_W  = 16;
   localparam int PROD_W    = TIME_W + WEIGHT_W;
   localparam int AGED_W    = PROD_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_WEIGHT = 2'd1;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic {
      POL_FIFO  = 1'b0,
      POL_AGING = 1'b1
   } policy_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     id;
      logic [PRIO_W-1:0]   prio;
      logic [TIME_W-1:0]   now;
   } cmd_type;

endpackage

[rtl/core/aprq_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: request, response and register write.
// Depends on aprq_pkg for field widths.
interface aprq_req_if
   import aprq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ID_W-1:0]   process_id;
   logic [PRIO_W-1:0] priority_req;
   logic [TIME_W-1:0] now;
   modport source (output valid, mode, process_id, priority_req, now, input ready);
   modport sink   (input valid, mode, process_id, priority_req, now, output ready);
endinterface

interface aprq_rsp_if
   import aprq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              valid_res;
   logic [ID_W-1:0]   out_id;
   logic [PRIO_W-1:0] aged_priority;
   logic              full_reject;
   modport source (output valid, valid_res, out_id, aged_priority, full_reject, input ready);
   modport sink   (input valid, valid_res, out_id, aged_priority, full_reject, output ready);
endinterface

interface aprq_csr_if
   import aprq_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/aprq_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on aprq_pkg and aprq_req_if.
module aprq_front
   import aprq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   aprq_req_if.sink   req,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req.ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push      = req.valid && req.ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      // classify the request into an operation
      slot_in.op   = req.mode ? OP_DEQ : OP_ENQ;
      slot_in.id   = req.process_id;
      slot_in.prio = req.priority_req;
      slot_in.now  = req.now;
      wr_ptr_in    = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("front queue overfilled");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> count_ff == 2'd2) else $error("front queue lost entry");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> wr_ptr_ff == rd_ptr_ff) else $error("front pointers diverged");

endmodule

[rtl/core/aprq_back.sv]
`timescale 1ns / 1ps
// Back end: chain of queue cells with a per-cell aging multiplier, the command
// sequencer, the configuration registers and the response register.
// Depends on aprq_pkg, aprq_rsp_if and aprq_csr_if.
module aprq_back
   import aprq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   aprq_csr_if.sink   csr,
   aprq_rsp_if.source rsp
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MUL    = 4'b0010,
      ST_CMP    = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cur_ff;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   policy_type           policy_ff;
   logic [WEIGHT_W-1:0]  weight_ff;

   logic [ID_W-1:0]      id_ff   [QUEUE_DEPTH];
   logic [PRIO_W-1:0]    prio_ff [QUEUE_DEPTH];
   logic [TIME_W-1:0]    time_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]      id_in   [QUEUE_DEPTH];
   logic [PRIO_W-1:0]    prio_in [QUEUE_DEPTH];
   logic [TIME_W-1:0]    time_in [QUEUE_DEPTH];
   logic [TIME_W-1:0]    elapsed [QUEUE_DEPTH];
   logic [PROD_W-1:0]    prod_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] lt_ff;
   logic [AGED_W-1:0]    head_aged_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 valid_res_ff, valid_res_in;
   logic [ID_W-1:0]      out_id_ff, out_id_in;
   logic [PRIO_W-1:0]    aged_out_ff, aged_out_in;
   logic                 reject_ff, reject_in;

   logic                 take, full, empty, commit_go;

   assign csr.ready = 1'b1;
   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign full      = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign empty     = (occ_ff == '0);
   // commit once the response register is free or being emptied this cycle
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.valid_res     = valid_res_ff;
   assign rsp.out_id        = out_id_ff;
   assign rsp.aged_priority = aged_out_ff;
   assign rsp.full_reject   = reject_ff;

   // elapsed time per cell, wrapping at the time width
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         elapsed[k] = cur_ff.now - time_ff[k];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (take) state_in = ST_MUL;
         ST_MUL:    state_in = ST_CMP;
         ST_CMP:    state_in = ST_COMMIT;
         ST_COMMIT: if (commit_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // cell chain update and response at commit
   always_comb begin
      logic shift_up;
      logic hit;
      shift_up     = 1'b0;
      hit          = 1'b0;
      occ_in       = occ_ff;
      valid_res_in = valid_res_ff;
      out_id_in    = out_id_ff;
      aged_out_in  = aged_out_ff;
      reject_in    = reject_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         id_in[k]   = id_ff[k];
         prio_in[k] = prio_ff[k];
         time_in[k] = time_ff[k];
      end
      if (commit_go) begin
         rsp_valid_in = 1'b1;
         valid_res_in = 1'b0;
         out_id_in    = '0;
         aged_out_in  = '0;
         reject_in    = 1'b0;
         if (cur_ff.op == OP_ENQ) begin
            if (full) begin
               reject_in = 1'b1;
            end else begin
               occ_in = occ_ff + OCC_W'(1);
               for (int k = 0; k < QUEUE_DEPTH; k++) begin
                  // insert at first lower-ranked entry or tail, shift rest up
                  hit = (policy_ff == POL_AGING) && lt_ff[k] && (OCC_W'(k) < occ_ff);
                  if (shift_up) begin
                     if (k > 0) begin
                        id_in[k]   = id_ff[k-1];
                        prio_in[k] = prio_ff[k-1];
                        time_in[k] = time_ff[k-1];
                     end
                  end else if (hit || OCC_W'(k) == occ_ff) begin
                     id_in[k]   = cur_ff.id;
                     prio_in[k] = cur_ff.prio;
                     time_in[k] = cur_ff.now;
                  end
                  shift_up = shift_up || hit || (OCC_W'(k) == occ_ff);
               end
            end
         end else if (!empty) begin
            occ_in       = occ_ff - OCC_W'(1);
            valid_res_in = 1'b1;
            out_id_in    = id_ff[0];
            aged_out_in  = (head_aged_ff[AGED_W-1:PRIO_W] != '0) ? '1
                                                                 : head_aged_ff[PRIO_W-1:0];
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
               id_in[k]   = id_ff[k+1];
               prio_in[k] = prio_ff[k+1];
               time_in[k] = time_ff[k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= POL_FIFO;
         weight_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.index == CSR_POLICY) begin
            policy_ff <= csr.data[0] ? POL_AGING : POL_FIFO;
         end
         if (csr.valid && csr.index == CSR_AGE_WEIGHT) begin
            weight_ff <= csr.data[WEIGHT_W-1:0];
         end
      end
   end

   // payload: command latch, cell chain, aging pipeline, response fields
   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= cmd;
      end
      if (state_ff == ST_MUL) begin
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            prod_ff[k] <= PROD_W'(elapsed[k]) * PROD_W'(weight_ff);
         end
      end
      if (state_ff == ST_CMP) begin
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            lt_ff[k] <= (AGED_W'(prio_ff[k]) + AGED_W'(prod_ff[k])) < AGED_W'(cur_ff.prio);
         end
         head_aged_ff <= AGED_W'(prio_ff[0]) + AGED_W'(prod_ff[0]);
      end
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         id_ff[k]   <= id_in[k];
         prio_ff[k] <= prio_in[k];
         time_ff[k] <= time_in[k];
      end
      valid_res_ff <= valid_res_in;
      out_id_ff    <= out_id_in;
      aged_out_ff  <= aged_out_in;
      reject_ff    <= reject_in;
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH)) else $error("occupancy beyond depth");
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT)) else $error("stray response");
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(valid_res_ff && reject_ff)) else $error("conflicting result flags");
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == ST_MUL) else $error("accepted command not started");

endmodule

[rtl/core/aging_priority_ready_queue.sv]
`timescale 1ns / 1ps
// Top level of the aging priority ready queue: front queue plus back cell chain.
// Depends on aprq_pkg, aprq_if, aprq_front and aprq_back.
//
//  channel | dir | handshake   | payload
//  req_ch  | in  | valid/ready | mode, process_id, priority_req, now
//  rsp_ch  | out | valid/ready | valid_res, out_id, aged_priority, full_reject
//  csr_ch  | in  | valid/ready | index, data (ready always high)
//
// Each item passes through the back-end sequencer (take, multiply elapsed time by
// weight in every cell, add and compare, commit); the back end takes no new item
// until the last one commits, and a response is offered once its item commits.
// The front holds up to two items.
// Reset is synchronous: it empties the queue and sets policy FIFO, weight zero.
// A stalled response holds the next commit; the front fills and then drops ready.
module aging_priority_ready_queue
   import aprq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   aprq_req_if.sink    req_ch,
   aprq_rsp_if.source  rsp_ch,
   aprq_csr_if.sink    csr_ch
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // classify and buffer requests
   aprq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // run them against the ordered cell chain
   aprq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .csr       (csr_ch),
      .rsp       (rsp_ch)
   );

endmodule

[verif/aging_priority_ready_queue_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the aging priority ready queue: directed and random
// enqueue/dequeue traffic under both policies. Depends on aprq_pkg, aprq_if, RTL.
module aging_priority_ready_queue_tb;
   import aprq_pkg::*;

   localparam int DEPTH = 16;

   typedef struct {
      logic              valid_res;
      logic [ID_W-1:0]   out_id;
      logic [PRIO_W-1:0] aged_priority;
      logic              full_reject;
   } sched_result_type;

   logic clock;
   logic reset;

   aprq_req_if req_ch ();
   aprq_rsp_if rsp_ch ();
   aprq_csr_if csr_ch ();

   aging_priority_ready_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Shadow copy of the ready queue, head at index 0.
   logic [ID_W-1:0]     shadow_id   [DEPTH];
   logic [PRIO_W-1:0]   shadow_prio [DEPTH];
   logic [TIME_W-1:0]   shadow_time [DEPTH];
   int                  shadow_count;
   policy_type          shadow_policy;
   logic [WEIGHT_W-1:0] shadow_weight;

   sched_result_type pending_results[$];
   int            error_count;
   int            sent_count;
   int            checked_count;
   int            dequeue_hits;
   int            full_hits;
   int            stall_mode;
   logic [TIME_W-1:0] clock_now;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TIMEOUT: %0d items still expected", pending_results.size());
      $display("TEST FAILED");
      $finish;
   end

   // Aged priority of one shadow entry at the given time, full 49-bit width.
   function automatic logic [AGED_W-1:0] aged_of(int k, logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] elapsed;
      elapsed = t - shadow_time[k];
      return AGED_W'(shadow_prio[k]) + AGED_W'(elapsed) * AGED_W'(shadow_weight);
   endfunction

   // Apply one accepted item to the shadow queue and queue the expected result.
   task automatic predict_schedule(op_type op, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] prio, logic [TIME_W-1:0] t);
      sched_result_type  r;
      int                pos;
      logic [AGED_W-1:0] aged;
      r = '{1'b0, '0, '0, 1'b0};
      if (op == OP_ENQ) begin
         if (shadow_count >= DEPTH) begin
            r.full_reject = 1'b1;
         end else begin
            pos = shadow_count;
            if (shadow_policy == POL_AGING) begin
               for (int k = 0; k < shadow_count; k++) begin
                  if (aged_of(k, t) < AGED_W'(prio)) begin
                     pos = k;
                     break;
                  end
               end
            end
            for (int k = shadow_count; k > pos; k--) begin
               shadow_id[k]   = shadow_id[k-1];
               shadow_prio[k] = shadow_prio[k-1];
               shadow_time[k] = shadow_time[k-1];
            end
            shadow_id[pos]   = id;
            shadow_prio[pos] = prio;
            shadow_time[pos] = t;
            shadow_count++;
         end
      end else if (shadow_count > 0) begin
         aged = aged_of(0, t);
         r.valid_res     = 1'b1;
         r.out_id        = shadow_id[0];
         r.aged_priority = (aged > AGED_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : aged[31:0];
         for (int k = 1; k < shadow_count; k++) begin
            shadow_id[k-1]   = shadow_id[k];
            shadow_prio[k-1] = shadow_prio[k];
            shadow_time[k-1] = shadow_time[k];
         end
         shadow_count--;
      end
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
   endtask

   // Drive one item and wait for its handshake; predict at acceptance.
   task automatic send_item(op_type op, logic [ID_W-1:0] id,
                            logic [PRIO_W-1:0] prio, logic [TIME_W-1:0] t);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= op;
      req_ch.process_id   <= id;
      req_ch.priority_req <= prio;
      req_ch.now          <= t;
      do @(posedge clock); while (!req_ch.ready);
      predict_schedule(op, id, prio, t);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic idle_sender(int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Random gap between bursts; hold valid low during it.
   task automatic maybe_gap();
      if ($urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 8));
   endtask

   // Wait for all expected items to drain, then let the pipe settle.
   task automatic drain();
      idle_sender(1);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // Raise the write and hold it to its handshake; the caller drops valid.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_POLICY) shadow_policy = policy_type'(value[0]);
      else if (idx == CSR_AGE_WEIGHT) shadow_weight = value;
      @(negedge clock);
   endtask

   task automatic set_mode(policy_type pol, logic [WEIGHT_W-1:0] weight);
      drain();
      write_csr(CSR_POLICY, CSR_DATA_W'(pol));
      write_csr(CSR_AGE_WEIGHT, weight);
      csr_ch.valid <= 1'b0;
   endtask

   // Empty the queue with dequeues so the next phase starts clean.
   task automatic flush_queue();
      while (shadow_count > 0) send_item(OP_DEQ, '0, '0, clock_now);
   endtask

   function automatic logic [PRIO_W-1:0] rand_prio();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 64);
         default: return $urandom();
      endcase
   endfunction

   // Receiver: stall on a slowly changing pattern; check at each handshake.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         checked_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_ch.out_id, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.valid_res !== want.valid_res)
               report_mismatch("valid_res", rsp_ch.valid_res, want.valid_res);
            if (rsp_ch.out_id !== want.out_id)
               report_mismatch("out_id", rsp_ch.out_id, want.out_id);
            if (rsp_ch.aged_priority !== want.aged_priority)
               report_mismatch("aged_priority", rsp_ch.aged_priority, want.aged_priority);
            if (rsp_ch.full_reject !== want.full_reject)
               report_mismatch("full_reject", rsp_ch.full_reject, want.full_reject);
            if (want.valid_res) dequeue_hits++;
            if (want.full_reject) full_hits++;
         end
      end
   end

   // Dequeue on empty, overfill, FIFO order at extreme field values.
   task automatic test_fifo_edges();
      send_item(OP_DEQ, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int k = 0; k < DEPTH + 2; k++)
         send_item(OP_ENQ, (k == 0) ? 8'hFF : 8'(k), (k[0]) ? 32'hFFFF_FFFF : '0, '0);
      send_item(OP_DEQ, '0, '0, 32'hFFFF_FFFF);
      flush_queue();
      send_item(OP_DEQ, '0, '0, '0);
   endtask

   // Aging: saturation, time wrap, ties kept in arrival order.
   task automatic test_aging_edges();
      set_mode(POL_AGING, 16'hFFFF);
      send_item(OP_ENQ, 8'h01, 32'hFFFF_0000, 32'h0000_0010);
      send_item(OP_ENQ, 8'h02, 32'd5, 32'h0000_0010);
      send_item(OP_ENQ, 8'h03, 32'd5, 32'h0000_0010);
      send_item(OP_ENQ, 8'h04, 32'd7, 32'h0000_0008);
      send_item(OP_DEQ, '0, '0, 32'h0000_0000);
      send_item(OP_DEQ, '0, '0, 32'h0000_0011);
      flush_queue();
      set_mode(POL_AGING, 16'd0);
      send_item(OP_ENQ, 8'h10, 32'd9, 32'd100);
      send_item(OP_ENQ, 8'h11, 32'd9, 32'd50);
      send_item(OP_ENQ, 8'h12, 32'd10, 32'd50);
      flush_queue();
   endtask

   // Random traffic: mostly valid enqueue/dequeue mixes, time mostly advancing.
   task automatic test_random_traffic(int count);
      op_type op;
      int     enq_bias;
      for (int n = 0; n < count; n++) begin
         if (n % 200 == 0) begin
            drain();
            case ((n / 200) % 4)
               0: set_mode(POL_AGING, 16'($urandom_range(0, 4)));
               1: set_mode(POL_FIFO, 16'($urandom()));
               2: set_mode(POL_AGING, 16'hFFFF);
               default: set_mode(POL_AGING, 16'($urandom()));
            endcase
            enq_bias = $urandom_range(30, 70);
         end
         if ($urandom_range(0, 9) == 0) clock_now = $urandom();
         else clock_now = clock_now + $urandom_range(0, 20);
         op = ($urandom_range(0, 99) < enq_bias) ? OP_ENQ : OP_DEQ;
         send_item(op, 8'($urandom()), rand_prio(), clock_now);
         maybe_gap();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.mode         = 1'b0;
      req_ch.process_id   = '0;
      req_ch.priority_req = '0;
      req_ch.now          = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      shadow_count        = 0;
      shadow_policy       = POL_FIFO;
      shadow_weight       = '0;
      error_count         = 0;
      sent_count          = 0;
      checked_count       = 0;
      dequeue_hits        = 0;
      full_hits           = 0;
      stall_mode          = 0;
      clock_now           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fifo_edges();
      test_aging_edges();
      test_random_traffic(1600);
      drain();

      $display("Covered %0d items, %0d checked: %0d dequeued entries, %0d full rejects.",
               sent_count, checked_count, dequeue_hits, full_hits);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d items left over", error_count,
                  pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
